/* rtl/core/llbm_pkg.sv */
// shared types, mode codes and the srgb-to-linear table builder for the blend mixer
package llbm_pkg;

    localparam int TAB_DEPTH = 256;
    localparam int ACC_BITS  = 30;

    typedef logic [31:0] tab_word_t;
    typedef tab_word_t lin_tab_t [TAB_DEPTH];

    typedef enum logic [3:0] {
        MODE_NORMAL     = 4'd0,
        MODE_MULTIPLY   = 4'd1,
        MODE_SCREEN     = 4'd2,
        MODE_OVERLAY    = 4'd3,
        MODE_DARKEN     = 4'd4,
        MODE_LIGHTEN    = 4'd5,
        MODE_DODGE      = 4'd6,
        MODE_BURN       = 4'd7,
        MODE_HARDLIGHT  = 4'd8,
        MODE_SOFTLIGHT  = 4'd9,
        MODE_DIFFERENCE = 4'd10,
        MODE_EXCLUSION  = 4'd11,
        MODE_SUBTRACT   = 4'd12,
        MODE_DIVIDE     = 4'd13
    } blend_mode_t;

    typedef struct packed {
        logic        ce;
        logic [3:0]  mode;
    } lane_ctrl_t;

    function automatic logic [63:0] q30_mul(input logic [63:0] a, input logic [63:0] b);
        q30_mul = (a * b) >> ACC_BITS;
    endfunction

    function automatic logic [63:0] pow5_q30(input logic [63:0] y);
        logic [63:0] y2;
        logic [63:0] y4;
        y2 = q30_mul(y, y);
        y4 = q30_mul(y2, y2);
        pow5_q30 = q30_mul(y4, y);
    endfunction

    // elaboration-time table: linear light value for each srgb code
    function automatic lin_tab_t build_lin_tab(input int frac);
        lin_tab_t    tab;
        logic [63:0] n;
        logic [63:0] a;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        logic [63:0] l30;
        logic [63:0] rnd;
        for (int v = 0; v < TAB_DEPTH; v++) begin
            if (v <= 10) begin
                n      = 64'(10 * v) << frac;
                tab[v] = 32'((n + 64'd32945) / 64'd32946);
            end else begin
                a  = 64'(1000 * v) + 64'd14025;
                x  = (a << ACC_BITS) / 64'd269025;
                x2 = q30_mul(x, x);
                lo = 64'd0;
                hi = 64'd1 << ACC_BITS;
                while (lo < hi) begin
                    mid = (lo + hi + 64'd1) >> 1;
                    if (pow5_q30(mid) <= x2) begin
                        lo = mid;
                    end else begin
                        hi = mid - 64'd1;
                    end
                end
                l30    = q30_mul(x2, lo);
                rnd    = (64'd1 << (ACC_BITS - frac)) - 64'd1;
                tab[v] = 32'((l30 + rnd) >> (ACC_BITS - frac));
            end
        end
        return tab;
    endfunction

endpackage

/* rtl/core/llbm_div.sv */
// pipelined restoring divider, one quotient bit per stage, saturating at one
module llbm_div #(
    parameter int FRAC = 15
) (
    input  logic                       aclk,
    input  llbm_pkg::lane_ctrl_t       ctrl,
    input  logic [FRAC:0]              num,
    input  logic [FRAC:0]              den,
    output logic [FRAC:0]              quo
);

    localparam int LW = FRAC + 1;

    logic [FRAC:0]   rem_reg [FRAC+1];
    logic [FRAC:0]   den_reg [FRAC+1];
    logic            sat_reg [FRAC+1];
    logic [FRAC-1:0] quo_reg [FRAC+1];

    logic [FRAC:0]   rem_next [1:FRAC];
    logic            ge       [1:FRAC];

    always_comb begin
        for (int i = 1; i <= FRAC; i++) begin
            logic [LW:0] sh;
            sh          = {rem_reg[i-1], 1'b0};
            ge[i]       = sh >= {1'b0, den_reg[i-1]};
            rem_next[i] = ge[i] ? LW'(sh - {1'b0, den_reg[i-1]}) : LW'(sh);
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.ce) begin
            rem_reg[0] <= num;
            den_reg[0] <= den;
            sat_reg[0] <= num >= den;
            quo_reg[0] <= '0;
            for (int i = 1; i <= FRAC; i++) begin
                rem_reg[i] <= rem_next[i];
                den_reg[i] <= den_reg[i-1];
                sat_reg[i] <= sat_reg[i-1];
                quo_reg[i] <= {quo_reg[i-1][FRAC-2:0], ge[i]};
            end
        end
    end

    assign quo = sat_reg[FRAC] ? {1'b1, {FRAC{1'b0}}} : {1'b0, quo_reg[FRAC]};

endmodule

/* rtl/core/llbm_sqrt.sv */
// pipelined digit-by-digit square root of b scaled by one, one root bit per stage
module llbm_sqrt #(
    parameter int FRAC = 15
) (
    input  logic                       aclk,
    input  llbm_pkg::lane_ctrl_t       ctrl,
    input  logic [FRAC:0]              rad,
    output logic [FRAC:0]              root
);

    localparam int LW = FRAC + 1;
    localparam int NW = 2 * LW;
    localparam int RW = FRAC + 4;

    logic [RW-1:0] rem_reg  [LW];
    logic [FRAC:0] root_reg [LW];
    logic [NW-1:0] n_reg    [LW];

    logic [RW-1:0] rem_next  [LW];
    logic [FRAC:0] root_next [LW];
    logic [NW-1:0] n_next    [LW];

    always_comb begin
        for (int j = 0; j < LW; j++) begin
            logic [RW-1:0] rem_in;
            logic [FRAC:0] root_in;
            logic [NW-1:0] n_in;
            logic [RW+1:0] rem_sh;
            logic [RW+1:0] trial;
            if (j == 0) begin
                rem_in  = '0;
                root_in = '0;
                n_in    = {1'b0, rad, {FRAC{1'b0}}};
            end else begin
                rem_in  = rem_reg[j-1];
                root_in = root_reg[j-1];
                n_in    = n_reg[j-1];
            end
            rem_sh    = {rem_in, n_in[NW-1:NW-2]};
            trial     = (RW+2)'({root_in, 2'b01});
            n_next[j] = {n_in[NW-3:0], 2'b00};
            if (rem_sh >= trial) begin
                rem_next[j]  = RW'(rem_sh - trial);
                root_next[j] = {root_in[FRAC-1:0], 1'b1};
            end else begin
                rem_next[j]  = RW'(rem_sh);
                root_next[j] = {root_in[FRAC-1:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.ce) begin
            for (int j = 0; j < LW; j++) begin
                rem_reg[j]  <= rem_next[j];
                root_reg[j] <= root_next[j];
                n_reg[j]    <= n_next[j];
            end
        end
    end

    assign root = root_reg[FRAC];

endmodule

/* rtl/core/llbm_lane.sv */
// one color channel: decode, blend, alpha lerp and srgb encode
module llbm_lane #(
    parameter int FRAC = 15
) (
    input  logic                       aclk,
    input  llbm_pkg::lane_ctrl_t       ctrl,
    input  logic [7:0]                 dst_code,
    input  logic [7:0]                 src_code,
    input  logic [7:0]                 sa,
    output logic [7:0]                 out_code
);

    localparam int LW        = FRAC + 1;
    localparam int PW        = 2 * LW;
    localparam int K         = FRAC + 1;
    localparam int SUM_W     = FRAC + 9;
    localparam int DIV_SHIFT = FRAC + 18;
    localparam int MUL_W     = FRAC + 12;
    localparam logic [63:0] DIV_MUL = ((64'd1 << DIV_SHIFT) + 64'd254) / 64'd255;
    localparam logic [LW-1:0] ONE  = LW'(1) << FRAC;
    localparam logic [LW-1:0] HALF = LW'(1) << (FRAC - 1);
    localparam llbm_pkg::lin_tab_t TAB = llbm_pkg::build_lin_tab(FRAC);

    // decode
    logic [LW-1:0] b1_reg, s1_reg;
    logic [7:0]    sa1_reg;

    // long unit alignment
    logic [LW-1:0] bd_reg  [K];
    logic [LW-1:0] sd_reg  [K];
    logic [7:0]    sad_reg [K];
    logic [LW-1:0] div_num, div_den, quo, root;

    // products
    logic [PW-1:0] bs2_reg, ov2_reg, sl2_reg;
    logic [LW-1:0] b2_reg, s2_reg, q2_reg;
    logic [7:0]    sa2_reg;
    logic [LW-1:0] sl_a, sl_b;

    // mix
    logic [LW-1:0] m_next, m3_reg, b3_reg;
    logic [7:0]    sa3_reg;

    // lerp
    logic [SUM_W-1:0] sum4_reg;
    logic [SUM_W+MUL_W-1:0] scaled;
    logic [LW-1:0]    f5_reg;

    // encode search
    logic [7:0]    n_reg [8];
    logic [LW-1:0] f_reg [8];
    logic [7:0]    n_next [8];

    always_ff @(posedge aclk) begin
        if (ctrl.ce) begin
            b1_reg  <= TAB[dst_code][LW-1:0];
            s1_reg  <= TAB[src_code][LW-1:0];
            sa1_reg <= sa;
        end
    end

    always_comb begin
        unique case (ctrl.mode)
            llbm_pkg::MODE_DODGE: begin
                div_num = b1_reg;
                div_den = ONE - s1_reg;
            end
            llbm_pkg::MODE_BURN: begin
                div_num = ONE - b1_reg;
                div_den = s1_reg;
            end
            default: begin
                div_num = b1_reg;
                div_den = s1_reg;
            end
        endcase
    end

    llbm_div #(.FRAC(FRAC)) u_div (
        .aclk (aclk),
        .ctrl (ctrl),
        .num  (div_num),
        .den  (div_den),
        .quo  (quo)
    );

    llbm_sqrt #(.FRAC(FRAC)) u_sqrt (
        .aclk (aclk),
        .ctrl (ctrl),
        .rad  (b1_reg),
        .root (root)
    );

    always_ff @(posedge aclk) begin
        if (ctrl.ce) begin
            bd_reg[0]  <= b1_reg;
            sd_reg[0]  <= s1_reg;
            sad_reg[0] <= sa1_reg;
            for (int i = 1; i < K; i++) begin
                bd_reg[i]  <= bd_reg[i-1];
                sd_reg[i]  <= sd_reg[i-1];
                sad_reg[i] <= sad_reg[i-1];
            end
        end
    end

    // soft light operands: low half uses (one-2s)*b, high half (2s-one)*(r-b)
    always_comb begin
        if (sd_reg[K-1] < HALF) begin
            sl_a = ONE - LW'({sd_reg[K-1], 1'b0});
            sl_b = bd_reg[K-1];
        end else begin
            sl_a = LW'({sd_reg[K-1], 1'b0} - {1'b0, ONE});
            sl_b = root - bd_reg[K-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.ce) begin
            bs2_reg <= bd_reg[K-1] * sd_reg[K-1];
            ov2_reg <= (ONE - bd_reg[K-1]) * (ONE - sd_reg[K-1]);
            sl2_reg <= sl_a * sl_b;
            b2_reg  <= bd_reg[K-1];
            s2_reg  <= sd_reg[K-1];
            q2_reg  <= quo;
            sa2_reg <= sad_reg[K-1];
        end
    end

    always_comb begin
        logic [LW:0]   mul;
        logic [LW:0]   mul2;
        logic [LW:0]   ovl;
        logic [LW:0]   bsum;
        logic [LW-1:0] t1;
        logic [PW-1:0] t2;
        mul  = (LW+1)'(bs2_reg >> FRAC);
        mul2 = (LW+1)'(bs2_reg >> (FRAC - 1));
        ovl  = (LW+1)'(ov2_reg >> (FRAC - 1));
        bsum = {1'b0, b2_reg} + {1'b0, s2_reg};
        t1   = LW'(sl2_reg >> FRAC);
        t2   = t1 * (ONE - b2_reg);
        unique case (ctrl.mode)
            llbm_pkg::MODE_MULTIPLY:   m_next = LW'(mul);
            llbm_pkg::MODE_SCREEN:     m_next = LW'(bsum - mul);
            llbm_pkg::MODE_OVERLAY:
                m_next = (b2_reg < HALF) ? LW'(mul2) : LW'({1'b0, ONE} - ovl);
            llbm_pkg::MODE_DARKEN:     m_next = (b2_reg < s2_reg) ? b2_reg : s2_reg;
            llbm_pkg::MODE_LIGHTEN:    m_next = (b2_reg > s2_reg) ? b2_reg : s2_reg;
            llbm_pkg::MODE_DODGE:      m_next = q2_reg;
            llbm_pkg::MODE_BURN:       m_next = ONE - q2_reg;
            llbm_pkg::MODE_HARDLIGHT:
                m_next = (s2_reg < HALF) ? LW'(mul2) : LW'({1'b0, ONE} - ovl);
            llbm_pkg::MODE_SOFTLIGHT:
                m_next = (s2_reg < HALF) ? LW'(b2_reg - LW'(t2 >> FRAC))
                                         : LW'(b2_reg + t1);
            llbm_pkg::MODE_DIFFERENCE:
                m_next = (b2_reg > s2_reg) ? b2_reg - s2_reg : s2_reg - b2_reg;
            llbm_pkg::MODE_EXCLUSION:  m_next = LW'(bsum - mul2);
            llbm_pkg::MODE_SUBTRACT:   m_next = (b2_reg > s2_reg) ? b2_reg - s2_reg : '0;
            llbm_pkg::MODE_DIVIDE:     m_next = q2_reg;
            default:                   m_next = s2_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (ctrl.ce) begin
            m3_reg  <= m_next;
            b3_reg  <= b2_reg;
            sa3_reg <= sa2_reg;
            sum4_reg <= SUM_W'(8'd255 - sa3_reg) * SUM_W'(b3_reg)
                      + SUM_W'(sa3_reg) * SUM_W'(m3_reg);
            f5_reg   <= LW'(scaled >> DIV_SHIFT);
        end
    end

    assign scaled = sum4_reg * MUL_W'(DIV_MUL);

    // binary search for the code, one bit per stage
    always_comb begin
        for (int j = 0; j < 8; j++) begin
            logic [7:0]    n_prev;
            logic [LW-1:0] f_in;
            logic [7:0]    cand;
            n_prev = (j == 0) ? 8'd0 : n_reg[j-1];
            f_in   = (j == 0) ? f5_reg : f_reg[j-1];
            cand   = n_prev | (8'd1 << (7 - j));
            n_next[j] = (TAB[cand][LW-1:0] <= f_in) ? cand : n_prev;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.ce) begin
            n_reg[0] <= n_next[0];
            f_reg[0] <= f5_reg;
            for (int j = 1; j < 8; j++) begin
                n_reg[j] <= n_next[j];
                f_reg[j] <= f_reg[j-1];
            end
        end
    end

    assign out_code = n_reg[7];

endmodule

/* rtl/core/linear_light_blend_mode_mixer.sv */
// top level: three color lanes, alpha path and the merging output register
//
//  channel   valid      ready      data        transaction
//  input     s_tvalid   s_tready   s_tdata     dest and source rgba pixel
//  output    m_tvalid   m_tready   m_tdata     composited rgba pixel
//  config    cfg_valid  cfg_ready  cfg_data    blend_mode write
//
//  one pixel per clock while the output is not stalled; the pipeline runs through
//  the divider and square root pipelines plus an 8-stage encode search
//  synchronous active-low reset clears the valid pipeline and blend_mode
//  a stalled output freezes the whole pipeline; pixel taken while output waits
//  only if the output register is being drained the same cycle
module linear_light_blend_mode_mixer #(
    parameter int LINEAR_FRAC_BITS = 15
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // dest_red, dest_green, dest_blue, dest_alpha,
                                   // src_red, src_green, src_blue, src_alpha
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // out_red, out_green, out_blue, out_alpha
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_data   // blend_mode
);

    localparam int LANE_LAT = LINEAR_FRAC_BITS + 14;
    localparam int A_SHIFT  = 25;
    localparam logic [63:0] A_MUL = ((64'd1 << A_SHIFT) + 64'd254) / 64'd255;

    logic                  ce;
    llbm_pkg::lane_ctrl_t  ctrl;
    logic [3:0]            mode_reg;
    logic [LANE_LAT-1:0]   vld_reg;
    logic                  m_tvalid_reg;
    logic [31:0]           m_tdata_reg;

    logic [15:0]           asum_reg;
    logic                  zero1_reg;
    logic [7:0]            ad_reg [LANE_LAT-1];
    logic                  zd_reg [LANE_LAT-1];
    logic [40:0]           ascaled;
    logic [7:0]            lane_code [3];

    logic [7:0] dest_alpha, src_alpha;

    assign dest_alpha = s_tdata[31:24];
    assign src_alpha  = s_tdata[63:56];

    assign ce        = m_tready | ~m_tvalid_reg;
    assign s_tready  = ce;
    assign cfg_ready = 1'b1;
    assign ctrl      = '{ce: ce, mode: mode_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= 4'(llbm_pkg::MODE_NORMAL);
            vld_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                mode_reg <= cfg_data;
            end
            if (ce) begin
                vld_reg      <= {vld_reg[LANE_LAT-2:0], s_tvalid};
                m_tvalid_reg <= vld_reg[LANE_LAT-1];
            end
        end
    end

    genvar c;
    generate
        for (c = 0; c < 3; c++) begin : g_lane
            llbm_lane #(.FRAC(LINEAR_FRAC_BITS)) u_lane (
                .aclk     (aclk),
                .ctrl     (ctrl),
                .dst_code (s_tdata[8*c +: 8]),
                .src_code (s_tdata[32+8*c +: 8]),
                .sa       (src_alpha),
                .out_code (lane_code[c])
            );
        end
    endgenerate

    // union alpha, aligned with the lanes
    assign ascaled = asum_reg * 25'(A_MUL);

    always_ff @(posedge aclk) begin
        if (ce) begin
            asum_reg  <= 16'(src_alpha) * 16'd255
                       + 16'(dest_alpha) * 16'(8'd255 - src_alpha);
            zero1_reg <= (src_alpha == 8'd0) && (dest_alpha == 8'd0);
            ad_reg[0] <= 8'(ascaled >> A_SHIFT);
            zd_reg[0] <= zero1_reg;
            for (int i = 1; i < LANE_LAT - 1; i++) begin
                ad_reg[i] <= ad_reg[i-1];
                zd_reg[i] <= zd_reg[i-1];
            end
            if (zd_reg[LANE_LAT-2]) begin
                m_tdata_reg <= '0;
            end else begin
                m_tdata_reg <= {ad_reg[LANE_LAT-2], lane_code[2], lane_code[1], lane_code[0]};
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

/* verif/tb_top.sv */
// self-checking testbench for the linear-light blend mode mixer
`timescale 1ns / 100ps

module tb_top;

    localparam int FRAC = 15;
    localparam int ONE = 1 << FRAC;
    localparam int LATENCY = FRAC + 15;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_PIXELS = 1200;

    typedef struct packed {
        logic [7:0] sa, sb, sg, sr, da, db, dg, dr;
    } pixel_pair_t;

    typedef struct packed {
        logic [7:0] a, b, g, r;
    } pixel_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [3:0]  cfg_data;

    linear_light_blend_mode_mixer #(.LINEAR_FRAC_BITS(FRAC)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    longint unsigned lin_lut [256];
    logic [3:0]  cur_mode;
    pixel_pair_t pending_pixels [$];
    pixel_t      expected_pixels [$];
    int          mismatch_count;
    int          accepted_count;
    int          checked_count;
    int          stall_cycles;
    bit          quiet_phase;
    bit          send_done;
    bit          timed_out;
    bit          send_gap;
    bit          recv_gap;

    always begin
        aclk = 1'b1;
        #1;
        aclk = 1'b0;
        #1;
    end

    function automatic longint unsigned mul30(longint unsigned a, longint unsigned b);
        return (a * b) >> 30;
    endfunction

    function automatic longint unsigned fifth_q30(longint unsigned y);
        longint unsigned y2;
        longint unsigned y4;
        y2 = mul30(y, y);
        y4 = mul30(y2, y2);
        return mul30(y4, y);
    endfunction

    task automatic fill_lin_lut();
        longint unsigned x, x2, lo, hi, mid, l30;
        for (int v = 0; v < 256; v++) begin
            if (v <= 10) begin
                lin_lut[v] = ((longint'(10 * v) << FRAC) + 32945) / 32946;
            end else begin
                x = ((longint'(1000 * v) + 14025) << 30) / 269025;
                x2 = mul30(x, x);
                lo = 0;
                hi = longint'(1) << 30;
                while (lo < hi) begin
                    mid = (lo + hi + 1) >> 1;
                    if (fifth_q30(mid) <= x2) lo = mid;
                    else hi = mid - 1;
                end
                l30 = mul30(x2, lo);
                lin_lut[v] = (l30 + (longint'(1) << (30 - FRAC)) - 1) >> (30 - FRAC);
            end
        end
    endtask

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned r;
        longint unsigned bitv;
        r = 0;
        bitv = longint'(1) << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= r + bitv) begin
                n -= r + bitv;
                r = (r >> 1) + bitv;
            end else begin
                r >>= 1;
            end
            bitv >>= 2;
        end
        return r;
    endfunction

    function automatic longint unsigned overlay_mix(longint unsigned b, longint unsigned s);
        if (b < ONE / 2) return (2 * b * s) >> FRAC;
        return ONE - ((2 * (ONE - b) * (ONE - s)) >> FRAC);
    endfunction

    function automatic longint unsigned blend_channel(logic [3:0] mode, longint unsigned b,
                                                      longint unsigned s);
        longint unsigned q;
        longint unsigned t;
        case (mode)
            llbm_pkg::MODE_MULTIPLY:   return (b * s) >> FRAC;
            llbm_pkg::MODE_SCREEN:     return b + s - ((b * s) >> FRAC);
            llbm_pkg::MODE_OVERLAY:    return overlay_mix(b, s);
            llbm_pkg::MODE_DARKEN:     return b < s ? b : s;
            llbm_pkg::MODE_LIGHTEN:    return b > s ? b : s;
            llbm_pkg::MODE_DODGE: begin
                if (s >= ONE) return ONE;
                q = (b << FRAC) / (ONE - s);
                return q < ONE ? q : ONE;
            end
            llbm_pkg::MODE_BURN: begin
                if (s == 0) return 0;
                q = ((ONE - b) << FRAC) / s;
                return ONE - (q < ONE ? q : ONE);
            end
            llbm_pkg::MODE_HARDLIGHT:  return overlay_mix(s, b);
            llbm_pkg::MODE_SOFTLIGHT: begin
                if (s < ONE / 2) begin
                    t = ((ONE - 2 * s) * b) >> FRAC;
                    t = (t * (ONE - b)) >> FRAC;
                    return b - t;
                end
                q = int_sqrt(b << FRAC);
                return b + (((2 * s - ONE) * (q - b)) >> FRAC);
            end
            llbm_pkg::MODE_DIFFERENCE: return b > s ? b - s : s - b;
            llbm_pkg::MODE_EXCLUSION:  return b + s - ((2 * b * s) >> FRAC);
            llbm_pkg::MODE_SUBTRACT:   return b > s ? b - s : 0;
            llbm_pkg::MODE_DIVIDE: begin
                if (s == 0) return ONE;
                q = (b << FRAC) / s;
                return q < ONE ? q : ONE;
            end
            default:         return s;
        endcase
    endfunction

    function automatic logic [7:0] srgb_encode(longint unsigned f);
        int n;
        n = 0;
        for (int k = 1; k < 256; k++)
            if (f >= lin_lut[k]) n++;
        return 8'(n);
    endfunction

    function automatic logic [7:0] composite_channel(logic [3:0] mode, logic [7:0] dc,
                                                     logic [7:0] sc, logic [7:0] sa);
        longint unsigned b, s, m;
        b = lin_lut[dc];
        s = lin_lut[sc];
        m = blend_channel(mode, b, s);
        return srgb_encode(((255 - sa) * b + sa * m) / 255);
    endfunction

    function automatic pixel_t composite_pixel(logic [3:0] mode, pixel_pair_t p);
        pixel_t o;
        o = '0;
        if (p.sa == 0 && p.da == 0) return o;
        o.r = composite_channel(mode, p.dr, p.sr, p.sa);
        o.g = composite_channel(mode, p.dg, p.sg, p.sa);
        o.b = composite_channel(mode, p.db, p.sb, p.sa);
        o.a = 8'((255 * int'(p.sa) + int'(p.da) * (255 - int'(p.sa))) / 255);
        return o;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch on pixel %0d %s: got %0d expected %0d",
                 checked_count, what, got, want);
        mismatch_count++;
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_pixels.push_back(composite_pixel(cur_mode, pixel_pair_t'(s_tdata)));
                accepted_count++;
            end
            if (!s_tvalid || s_tready) begin
                send_gap = !quiet_phase && ($urandom_range(99) < 36);
                if (pending_pixels.size() > 0 && !send_gap) begin
                    s_tvalid <= 1'b1;
                    s_tdata <= pending_pixels.pop_front();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        pixel_t got;
        pixel_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (expected_pixels.size() == 0) begin
                    report_mismatch("unexpected pixel", int'(m_tdata), 0);
                end else begin
                    want = expected_pixels.pop_front();
                    if (got.r !== want.r) report_mismatch("red", got.r, want.r);
                    if (got.g !== want.g) report_mismatch("green", got.g, want.g);
                    if (got.b !== want.b) report_mismatch("blue", got.b, want.b);
                    if (got.a !== want.a) report_mismatch("alpha", got.a, want.a);
                    checked_count++;
                end
            end
            recv_gap = !quiet_phase && ($urandom_range(99) < 36);
            m_tready <= !recv_gap;
        end
    end

    // watchdog on transaction progress
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (pending_pixels.size() == 0 && expected_pixels.size() == 0 && !s_tvalid)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT) timed_out = 1'b1;
        end
    end

    task automatic set_mode(logic [3:0] mode);
        wait (pending_pixels.size() == 0 && !s_tvalid && expected_pixels.size() == 0);
        repeat (LATENCY + 5) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= mode;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        cur_mode = mode;
    endtask

    function automatic pixel_pair_t random_pair();
        pixel_pair_t p;
        p = pixel_pair_t'({$urandom, $urandom});
        case ($urandom_range(7))
            0: p.sa = 8'd0;
            1: p.sa = 8'd255;
            2: begin p.sa = 8'd0; p.da = 8'd0; end
            3: p.sr = 8'($urandom_range(12));
            default: ;
        endcase
        return p;
    endfunction

    task automatic queue_directed();
        pending_pixels.push_back({8'd255, 8'd255, 8'd255, 8'd255,
                                  8'd255, 8'd255, 8'd255, 8'd255});
        pending_pixels.push_back('0);
        pending_pixels.push_back({8'd0, 8'd200, 8'd90, 8'd10, 8'd128, 8'd77, 8'd5, 8'd250});
        pending_pixels.push_back({8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0});
        pending_pixels.push_back({8'd128, 8'd11, 8'd10, 8'd188, 8'd0, 8'd187, 8'd1, 8'd9});
        pending_pixels.push_back({8'd1, 8'd128, 8'd3, 8'd254, 8'd254, 8'd127, 8'd200, 8'd60});
    endtask

    initial begin
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        cur_mode = llbm_pkg::MODE_NORMAL;
        quiet_phase = 1'b0;
        send_done = 1'b0;
        fill_lin_lut();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // reset mode first, then every code including the unused ones
        queue_directed();
        for (int m = 0; m < 16; m++) begin
            set_mode(4'(m));
            queue_directed();
        end
        for (int phase = 0; phase < 24; phase++) begin
            set_mode(phase < 2 ? 4'(phase * 15) : 4'($urandom_range(15)));
            quiet_phase = (phase == 5);
            for (int i = 0; i < RANDOM_PIXELS / 24; i++)
                pending_pixels.push_back(random_pair());
        end
        wait (pending_pixels.size() == 0 && !s_tvalid && expected_pixels.size() == 0);
        send_done = 1'b1;
    end

    initial begin
        wait (send_done || timed_out);
        if (timed_out) begin
            $display("linear_light_blend_mode_mixer test failed");
            $finish;
        end else begin
            repeat (LATENCY + 10) @(posedge aclk);
            $display("covered %0d pixels, all sixteen mode codes, alpha and edge codes",
                     accepted_count);
            $display("checked %0d pixels, %0d mismatches", checked_count, mismatch_count);
            if (mismatch_count == 0 && expected_pixels.size() == 0)
                $display("linear_light_blend_mode_mixer test passed");
            else
                $display("linear_light_blend_mode_mixer test failed");
            $finish;
        end
    end
endmodule
